@@ rtl/mips_r6_compact_branch_resolve_macros.svh @@
// assertion helpers for the checker module
`ifndef MIPS_R6_COMPACT_BRANCH_RESOLVE_MACROS_SVH
`define MIPS_R6_COMPACT_BRANCH_RESOLVE_MACROS_SVH

// same-cycle implication, off during reset
`define MRCB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with a delayed consequent
`define MRCB_ASSERT_LATER(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> ##1 (cons)) \
		else $error(msg);

// next-cycle implication
`define MRCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mrcb_pkg.sv @@
package mrcb_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_NONE = 2'd0;
	localparam status_t ST_OK   = 2'd1;
	localparam status_t ST_RI   = 2'd2;

	localparam logic [5:0] OP_POP06 = 6'h06;
	localparam logic [5:0] OP_POP07 = 6'h07;
	localparam logic [5:0] OP_POP10 = 6'h08;
	localparam logic [5:0] OP_POP30 = 6'h18;
	localparam logic [5:0] OP_POP26 = 6'h16;
	localparam logic [5:0] OP_POP27 = 6'h17;
	localparam logic [5:0] OP_BC    = 6'h32;
	localparam logic [5:0] OP_BALC  = 6'h3A;
	localparam logic [5:0] OP_POP66 = 6'h36;
	localparam logic [5:0] OP_POP76 = 6'h3E;

	localparam logic [31:0] INSTR_BYTES = 32'd4;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] pc;
		logic [31:0] rs_value;
		logic [31:0] rt_value;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic        taken;
		logic [31:0] next_pc;
		logic        link_write;
		logic [31:0] link_value;
	} rsp_t;

endpackage

@@ rtl/mrcb_req_if.sv @@
interface mrcb_req_if;
	logic             valid;
	logic             ready;
	mrcb_pkg::req_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mrcb_rsp_if.sv @@
interface mrcb_rsp_if;
	logic             valid;
	logic             ready;
	mrcb_pkg::rsp_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/mips_r6_compact_branch_resolve.sv @@
// Compact branch resolver for MIPS32 Release 6: each item carries an instruction word, its pc
// and the rs/rt register values, and yields one result with status, taken, next pc and the r31
// link write. Throughput is one item per cycle while the output takes results. The input
// register takes the item when it is accepted, and the result register then loads from it
// once the output side has room. The decode, the compares and the pc+4 add feeding the target
// add sit between those two registers. A result that waits on the output holds the result
// register. The input register then moves only if it is empty. Otherwise the input side stalls
// until the result is taken.
module mips_r6_compact_branch_resolve (
	input  logic        clk,
	input  logic        arst_n,
	mrcb_req_if.sink    req,
	mrcb_rsp_if.source  rsp
);
	import mrcb_pkg::*;

	// input register stage
	logic        valid_s1;
	req_t        item_s1;
	// result register stage
	logic        valid_s2;
	rsp_t        res_s2;

	logic        adv_s2;
	logic        adv_s1;

	// decode fields
	logic [5:0]  op;
	logic [4:0]  rs;
	logic [4:0]  rt;
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] seq;
	logic [31:0] off16;
	logic [31:0] off21;
	logic [31:0] off26;
	logic [31:0] jofs;
	logic [31:0] base;
	logic [31:0] ofs;
	logic [31:0] target;
	logic [31:0] sum;
	logic        ovf;
	logic        b_lez;
	logic        b_gtz;
	logic        a_eq_b;
	logic        a_slt_b;
	status_t     status;
	logic        taken;
	logic        link;
	rsp_t        res;

	// stage 2 can load when empty or when its item is taken this cycle
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	assign op  = item_s1.instr_word[31:26];
	assign rs  = item_s1.instr_word[25:21];
	assign rt  = item_s1.instr_word[20:16];
	assign a   = item_s1.rs_value;
	assign b   = item_s1.rt_value;
	assign seq = item_s1.pc + INSTR_BYTES;

	// branch offsets are word offsets, jic/jialc offset is a byte offset
	assign off16 = {{14{item_s1.instr_word[15]}}, item_s1.instr_word[15:0], 2'b00};
	assign off21 = {{9{item_s1.instr_word[20]}}, item_s1.instr_word[20:0], 2'b00};
	assign off26 = {{4{item_s1.instr_word[25]}}, item_s1.instr_word[25:0], 2'b00};
	assign jofs  = {{16{item_s1.instr_word[15]}}, item_s1.instr_word[15:0]};

	// compare helpers
	assign sum     = a + b;
	assign ovf     = (a[31] == b[31]) && (sum[31] != a[31]);
	assign b_lez   = b[31] || (b == 32'd0);
	assign b_gtz   = !b_lez;
	assign a_eq_b  = (a == b);
	assign a_slt_b = $signed(a) < $signed(b);

	always_comb begin
		status = ST_OK;
		taken  = 1'b0;
		link   = 1'b0;
		base   = seq;
		ofs    = off16;
		case (op)
			OP_BC, OP_BALC: begin
				ofs   = off26;
				taken = 1'b1;
				link  = (op == OP_BALC);
			end
			OP_POP06: begin
				// legacy blez when rt is zero
				if (rt == 5'd0) begin
					status = ST_NONE;
				end else if (rs == 5'd0) begin
					link  = 1'b1;
					taken = b_lez;
				end else if (rs == rt) begin
					link  = 1'b1;
					taken = !b[31];
				end else begin
					taken = (a >= b);
				end
			end
			OP_POP07: begin
				// legacy bgtz when rt is zero
				if (rt == 5'd0) begin
					status = ST_NONE;
				end else if (rs == 5'd0) begin
					link  = 1'b1;
					taken = b_gtz;
				end else if (rs == rt) begin
					link  = 1'b1;
					taken = b[31];
				end else begin
					taken = (a < b);
				end
			end
			OP_POP10: begin
				if (rs >= rt) begin
					taken = ovf;
				end else if (rs == 5'd0) begin
					link  = 1'b1;
					taken = (b == 32'd0);
				end else begin
					taken = a_eq_b;
				end
			end
			OP_POP30: begin
				if (rs >= rt) begin
					taken = !ovf;
				end else if (rs == 5'd0) begin
					link  = 1'b1;
					taken = (b != 32'd0);
				end else begin
					taken = !a_eq_b;
				end
			end
			OP_POP26: begin
				if (rt == 5'd0) begin
					status = ST_RI;
				end else if (rs == 5'd0) begin
					taken = b_lez;
				end else if (rs == rt) begin
					taken = !b[31];
				end else begin
					taken = !a_slt_b;
				end
			end
			OP_POP27: begin
				if (rt == 5'd0) begin
					status = ST_RI;
				end else if (rs == 5'd0) begin
					taken = b_gtz;
				end else if (rs == rt) begin
					taken = b[31];
				end else begin
					taken = a_slt_b;
				end
			end
			OP_POP66, OP_POP76: begin
				if (rs != 5'd0) begin
					// beqzc / bnezc
					ofs   = off21;
					taken = (op == OP_POP66) ? (a == 32'd0) : (a != 32'd0);
				end else begin
					// jic / jialc
					base  = b;
					ofs   = jofs;
					taken = 1'b1;
					link  = (op == OP_POP76);
				end
			end
			default: begin
				status = ST_NONE;
			end
		endcase
		if (status != ST_OK) begin
			taken = 1'b0;
			link  = 1'b0;
		end
	end

	assign target = base + ofs;

	always_comb begin
		res.status     = status;
		res.taken      = taken;
		res.next_pc    = taken ? target : seq;
		res.link_write = link;
		res.link_value = link ? seq : 32'd0;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			item_s1 <= req.data;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = res_s2;

endmodule

@@ rtl/mrcb_checker.sv @@
`include "mips_r6_compact_branch_resolve_macros.svh"

module mrcb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input mrcb_pkg::rsp_t rsp_data
);
	import mrcb_pkg::*;

	// a stalled result keeps its payload
	`MRCB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
	// anything but a resolved branch neither branches nor links
	`MRCB_ASSERT_NOW(a_non_branch_quiet, rsp_valid && (rsp_data.status != ST_OK), !rsp_data.taken && !rsp_data.link_write, "non-branch result taken or linking")
	// link value only shows up with a link write
	`MRCB_ASSERT_NOW(a_link_value_zero, rsp_valid && !rsp_data.link_write, rsp_data.link_value == 32'd0, "link value without link write")
	// an accepted item is checked for a valid result on the output through the delayed implication
	`MRCB_ASSERT_LATER(a_item_reaches_out, req_valid && req_ready, rsp_valid, "accepted item did not reach the output")

endmodule

bind mips_r6_compact_branch_resolve mrcb_checker u_mrcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
